// ===== rtl/core/vlpd_pkg.sv =====
package vlpd_pkg;

    localparam int BYTE_W = 8;
    localparam int HDR_W  = 16;
    localparam int ID_W   = 14;
    localparam int LCNT_W = 2;
    localparam int LEN_W  = 24;
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // One result word from the parser
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic [BYTE_W-1:0] data;
        logic              last;
    } res_t;

endpackage

// ===== rtl/core/vlpd_if.sv =====
interface vlpd_in_if;
    import vlpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              link_error;

    modport source (output valid, output rx_byte, output link_error, input ready);
    modport sink   (input valid, input rx_byte, input link_error, output ready);
endinterface

interface vlpd_out_if;
    import vlpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   message_id;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;

    modport source (output valid, output kind, output message_id, output payload_byte,
                    output last, input ready);
    modport sink   (input valid, input kind, input message_id, input payload_byte,
                    input last, output ready);
endinterface

// ===== rtl/core/variable_length_prefix_deframer.sv =====
// Length-prefixed message deframer. Each rx word carries one stream byte or a
// link error; each payload byte leaves as one msg word tagged with the 14-bit
// message id, the final one flagged last. A frame with zero payload length
// yields one empty-message word, and a link error yields one error word and
// restarts header hunting. Header and length bytes produce no output. One rx
// word is taken every cycle while msg keeps up; a word passes an input
// register and then the frame state update, and its result is registered
// into the result register once that slot is free or draining. The one-word
// input and output registers pace the flow: a stall on msg holds both and
// backs up rx.
module variable_length_prefix_deframer (
    input  logic          clk,
    input  logic          rst_n,
    vlpd_in_if.sink       rx,
    vlpd_out_if.source    msg
);
    import vlpd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_err_reg;

    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic              step;
    res_t              res;

    // Consume the held word when the result slot is free or draining
    assign step     = in_valid_reg && (!out_valid_reg || msg.ready);
    assign rx.ready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
            in_err_reg  <= rx.link_error;
        end
    end

    vlpd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (in_byte_reg),
        .link_error (in_err_reg),
        .res        (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (msg.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            out_kind_reg <= res.kind;
            out_id_reg   <= res.id;
            out_data_reg <= res.data;
            out_last_reg <= res.last;
        end
    end

    assign msg.valid        = out_valid_reg;
    assign msg.kind         = out_kind_reg;
    assign msg.message_id   = out_id_reg;
    assign msg.payload_byte = out_data_reg;
    assign msg.last         = out_last_reg;

    // A consumed link error always shows up as an error word next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_err_reg) |=> (out_valid_reg && out_kind_reg == KIND_ERROR))
        else $error("link error did not produce an error word");

    // Error words carry no id and no last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_ERROR) |-> (out_id_reg == '0 && !out_last_reg))
        else $error("error word carries frame fields");

    // Empty messages are always last with a zero data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_EMPTY) |-> (out_last_reg && out_data_reg == '0))
        else $error("malformed empty-message word");

    // The result slot never loads while a stalled word is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !msg.ready) |-> !step)
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/vlpd_parser.sv =====
module vlpd_parser (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [vlpd_pkg::BYTE_W-1:0] rx_byte,
    input  logic                    link_error,
    output vlpd_pkg::res_t          res
);
    import vlpd_pkg::*;

    typedef enum logic [1:0] {
        PH_HDR_HI = 2'd0,
        PH_HDR_LO = 2'd1,
        PH_LEN    = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [HDR_W-1:0]    hdr_reg, hdr_next;
    logic [LCNT_W-1:0]   lcnt_reg, lcnt_next;
    logic [LEN_W-1:0]    plen_reg, plen_next;

    logic [HDR_W-1:0]    hdr_lo;
    logic [LEN_W-1:0]    plen_shift;
    logic [LCNT_W-1:0]   lcnt_dec;
    logic [LEN_W-1:0]    plen_dec;

    assign hdr_lo     = {hdr_reg[HDR_W-1:BYTE_W], rx_byte};
    assign plen_shift = {plen_reg[LEN_W-BYTE_W-1:0], rx_byte};
    assign lcnt_dec   = lcnt_reg - LCNT_W'(1);
    assign plen_dec   = plen_reg - LEN_W'(1);

    // Decode one byte against the current frame phase
    always_comb
    begin
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        lcnt_next  = lcnt_reg;
        plen_next  = plen_reg;
        res        = '0;
        res.kind   = KIND_DATA;

        if (link_error)
        begin
            res.valid  = 1'b1;
            res.kind   = KIND_ERROR;
            phase_next = PH_HDR_HI;
            hdr_next   = '0;
            lcnt_next  = '0;
            plen_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PH_HDR_HI:
                begin
                    hdr_next   = {rx_byte, {BYTE_W{1'b0}}};
                    phase_next = PH_HDR_LO;
                end
                PH_HDR_LO:
                begin
                    hdr_next  = hdr_lo;
                    lcnt_next = hdr_lo[LCNT_W-1:0];
                    plen_next = '0;
                    if (hdr_lo[LCNT_W-1:0] == '0)
                    begin
                        // no length bytes: empty message right away
                        res.valid  = 1'b1;
                        res.kind   = KIND_EMPTY;
                        res.id     = hdr_lo[HDR_W-1:LCNT_W];
                        res.last   = 1'b1;
                        phase_next = PH_HDR_HI;
                        hdr_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (lcnt_reg == '0)
                    begin
                        // length already complete
                        if (plen_reg == '0)
                        begin
                            res.valid  = 1'b1;
                            res.kind   = KIND_EMPTY;
                            res.id     = hdr_reg[HDR_W-1:LCNT_W];
                            res.last   = 1'b1;
                            phase_next = PH_HDR_HI;
                            hdr_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    else
                    begin
                        plen_next = plen_shift;
                        lcnt_next = lcnt_dec;
                        if (lcnt_dec == '0)
                        begin
                            if (plen_shift == '0)
                            begin
                                res.valid  = 1'b1;
                                res.kind   = KIND_EMPTY;
                                res.id     = hdr_reg[HDR_W-1:LCNT_W];
                                res.last   = 1'b1;
                                phase_next = PH_HDR_HI;
                                hdr_next   = '0;
                                lcnt_next  = '0;
                                plen_next  = '0;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_DATA;
                    res.id    = hdr_reg[HDR_W-1:LCNT_W];
                    res.data  = rx_byte;
                    res.last  = (plen_dec == '0);
                    plen_next = plen_dec;
                    if (plen_dec == '0)
                    begin
                        phase_next = PH_HDR_HI;
                        hdr_next   = '0;
                        lcnt_next  = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR_HI;
                end
            endcase
        end
    end

    // Hold frame state; advance only when a word is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR_HI;
            hdr_reg   <= '0;
            lcnt_reg  <= '0;
            plen_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            lcnt_reg  <= lcnt_next;
            plen_reg  <= plen_next;
        end
    end

endmodule

// ===== tb/sv/vlpd_deframe_checker.sv =====
module vlpd_deframe_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rx_valid,
    input  logic                          rx_ready,
    input  logic [vlpd_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          link_error,
    input  logic                          msg_valid,
    input  logic                          msg_ready,
    input  logic [vlpd_pkg::KIND_W-1:0]   kind,
    input  logic [vlpd_pkg::ID_W-1:0]     message_id,
    input  logic [vlpd_pkg::BYTE_W-1:0]   payload_byte,
    input  logic                          last,
    output int                            fail_count,
    output int                            pending_words
);
    import vlpd_pkg::*;

    typedef enum logic [1:0] {
        WAIT_HDR_HI,
        WAIT_HDR_LO,
        READ_LEN,
        PASS_DATA
    } frame_phase_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic [BYTE_W-1:0] data;
        logic              last;
    } msg_word_t;

    frame_phase_t      phase;
    logic [HDR_W-1:0]  header;
    logic [LCNT_W-1:0] len_left;
    logic [LEN_W-1:0]  remaining;
    msg_word_t         expected_words[$];
    msg_word_t         want;

    // Drop the current frame and hunt for the next header
    function automatic void restart_hunt();
        phase     = WAIT_HDR_HI;
        header    = '0;
        len_left  = '0;
        remaining = '0;
    endfunction

    // Length is complete: either an empty message or the start of the payload
    function automatic void close_length();
        if (remaining == '0)
        begin
            expected_words.push_back('{kind: KIND_EMPTY, id: header[HDR_W-1:LCNT_W],
                                       data: '0, last: 1'b1});
            restart_hunt();
        end
        else
        begin
            phase = PASS_DATA;
        end
    endfunction

    // Advance the frame state by one received word and queue what it yields
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b, input logic err);
        logic [LEN_W-1:0] left;
        if (err)
        begin
            expected_words.push_back('{kind: KIND_ERROR, id: '0, data: '0, last: 1'b0});
            restart_hunt();
        end
        else
        begin
            case (phase)
                WAIT_HDR_HI:
                begin
                    header = {b, 8'h00};
                    phase  = WAIT_HDR_LO;
                end
                WAIT_HDR_LO:
                begin
                    header[BYTE_W-1:0] = b;
                    len_left  = b[LCNT_W-1:0];
                    remaining = '0;
                    if (len_left == '0)
                        close_length();
                    else
                        phase = READ_LEN;
                end
                READ_LEN:
                begin
                    if (len_left == '0)
                    begin
                        close_length();
                    end
                    else
                    begin
                        remaining = {remaining[LEN_W-BYTE_W-1:0], b};
                        len_left  = len_left - 1'b1;
                        if (len_left == '0)
                            close_length();
                    end
                end
                default:
                begin
                    left = remaining - 1'b1;
                    expected_words.push_back('{kind: KIND_DATA,
                                               id: header[HDR_W-1:LCNT_W],
                                               data: b, last: (left == '0)});
                    remaining = left;
                    if (left == '0)
                        restart_hunt();
                end
            endcase
        end
    endfunction

    task automatic check_field(input string field, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            fail_count++;
            $display("%0t: msg %s mismatch: expected %0h, actual %0h",
                     $time, field, exp_val, act_val);
        end
    endtask

    // Predict on every accepted rx word, compare on every accepted msg word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_hunt();
            expected_words.delete();
            pending_words = 0;
            fail_count    = 0;
        end
        else
        begin
            if (rx_valid && rx_ready)
                deframe_byte(rx_byte, link_error);
            if (msg_valid && msg_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    $display({"%0t: unexpected msg word: expected none, ",
                              "actual kind=%0d id=%0h data=%0h last=%0b"},
                             $time, kind, message_id, payload_byte, last);
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("message_id", want.id, message_id);
                    check_field("payload_byte", want.data, payload_byte);
                    check_field("last", want.last, last);
                end
            end
            pending_words = expected_words.size();
        end
    end

endmodule

// ===== tb/sv/tb_variable_length_prefix_deframer.sv =====
module tb_variable_length_prefix_deframer;
    import vlpd_pkg::*;

    localparam int TOTAL_WORDS = 1250;
    localparam int TAIL_START  = 1100;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;
    int   sent_items = 0;
    logic quiet_tail = 1'b0;
    logic hold_request = 1'b0;
    int   fail_count;
    int   pending_words;
    logic idling_allowed;

    vlpd_in_if  rx_bus();
    vlpd_out_if msg_bus();

    always #1 clk = ~clk;

    // Leave stretches without idling, and none at all near the end
    assign idling_allowed = !quiet_tail && ((sent_items % 200) >= 40);

    variable_length_prefix_deframer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus),
        .msg   (msg_bus)
    );

    vlpd_deframe_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_bus.valid),
        .rx_ready     (rx_bus.ready),
        .rx_byte      (rx_bus.rx_byte),
        .link_error   (rx_bus.link_error),
        .msg_valid    (msg_bus.valid),
        .msg_ready    (msg_bus.ready),
        .kind         (msg_bus.kind),
        .message_id   (msg_bus.message_id),
        .payload_byte (msg_bus.payload_byte),
        .last         (msg_bus.last),
        .fail_count   (fail_count),
        .pending_words(pending_words)
    );

    // Offer one rx word, with an occasional idle burst ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic err);
        int gap;
        if (idling_allowed && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            rx_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_bus.valid      <= 1'b1;
        rx_bus.rx_byte    <= b;
        rx_bus.link_error <= err;
        do
            @(posedge clk);
        while (!rx_bus.ready);
        sent_items++;
        @(negedge clk);
    endtask

    // Send one frame; a cut point aborts it with a link error at that word
    task automatic send_frame(input logic [ID_W-1:0] id, input logic [LCNT_W-1:0] nlen,
                              input int unsigned plen, input int cut_at);
        logic [HDR_W-1:0] hdr;
        int total;
        int k;
        hdr   = {id, nlen};
        total = 2 + nlen + plen;
        k     = 0;
        while (k < total)
        begin
            if (k == cut_at)
            begin
                send_byte($urandom, 1'b1);
                k = total;
            end
            else
            begin
                if (k == 0)
                    send_byte(hdr[HDR_W-1:BYTE_W], 1'b0);
                else if (k == 1)
                    send_byte(hdr[BYTE_W-1:0], 1'b0);
                else if (k < 2 + nlen)
                    send_byte(plen >> (BYTE_W * (1 + nlen - k)), 1'b0);
                else
                    send_byte($urandom, 1'b0);
                k++;
            end
        end
    endtask

    // Receiver: one long hold for back-pressure, otherwise random stall bursts
    initial
    begin : msg_sink
        int gap;
        bit held;
        held = 1'b0;
        msg_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !held)
            begin
                held = 1'b1;
                msg_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (idling_allowed && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 11);
                msg_bus.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                msg_bus.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned pick;
        int unsigned plen;
        int unsigned len_mask;
        logic [LCNT_W-1:0] nlen;
        int n;
        int cut;
        rst_n             = 1'b0;
        rx_bus.valid      = 1'b0;
        rx_bus.rx_byte    = '0;
        rx_bus.link_error = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Link error while hunting, rx byte ignored
        send_byte(8'hFF, 1'b1);
        // Largest id, no length bytes: empty message from the header itself
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFC, 1'b0);
        // Id zero, three length bytes all zero: empty message
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // Two length bytes, two payload bytes 8'h00 and 8'h80
        send_byte(8'h12, 1'b0);
        send_byte(8'h36, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        // Link error on the header low byte
        send_byte(8'h40, 1'b0);
        send_byte(8'h00, 1'b1);
        // Link error in the length bytes
        send_byte(8'h02, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hAA, 1'b1);
        // Link error in the payload of a huge frame
        send_byte(8'h7F, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);

        hold_request = 1'b1;

        while (sent_items < TOTAL_WORDS)
        begin
            if (sent_items >= TAIL_START)
                quiet_tail = 1'b1;
            pick = $urandom_range(0, 99);
            nlen = $urandom_range(0, 3);
            len_mask = (1 << (BYTE_W * nlen)) - 1;
            if (pick < 70)
            begin
                // Well-formed frame, mostly short payloads
                n = $urandom_range(0, 19);
                if (n == 0)
                    plen = 0;
                else if (n < 15)
                    plen = $urandom_range(1, 8);
                else if (n < 19)
                    plen = $urandom_range(9, 40);
                else
                    plen = $urandom_range(200, 300);
                plen = (plen > len_mask) ? len_mask : plen;
                send_frame($urandom, nlen, plen, -1);
            end
            else if (pick < 85)
            begin
                // Frame with any length, aborted early by a link error
                plen = $urandom & len_mask;
                cut  = $urandom_range(0, 1 + nlen + ((plen < 6) ? plen : 6));
                send_frame($urandom, nlen, plen, cut);
            end
            else if (pick < 95)
            begin
                // Random noise, then a link error to resynchronize
                n = $urandom_range(1, 6);
                repeat (n) send_byte($urandom, $urandom_range(0, 7) == 0);
                send_byte($urandom, 1'b1);
            end
            else
            begin
                send_byte($urandom, 1'b1);
            end
        end

        rx_bus.valid <= 1'b0;
        wait (pending_words == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS variable_length_prefix_deframer");
        else
            $display("FAIL variable_length_prefix_deframer");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("FAIL variable_length_prefix_deframer");
        $finish;
    end

endmodule
